>>> rtl/psms_pkg.sv
// Shared types and constants for the packed symmetric matrix store.
// Holds operation and status codes, controller/datapath command and status
// structs, and the packed triangle slot function. No dependencies.
package psms_pkg;

  localparam int FUNC_W   = 2;
  localparam int IDX_W    = 6;
  localparam int OPV_W    = 32;
  localparam int STATUS_W = 2;
  localparam int DIM_W    = 7;
  localparam int SLOT_W   = 2 * DIM_W - 1;

  localparam logic [DIM_W-1:0] RESET_DIM = 7'd64;

  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUB   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SWAP  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EQUAL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_RD_AB,
    MEM_WR_AB,
    MEM_SUB_AB,
    MEM_RD_P,
    MEM_RD_Q,
    MEM_WR_P,
    MEM_WR_Q
  } mem_op_t;

  typedef struct packed {
    logic    load_req;
    logic    clr_step;
    mem_op_t mem_op;
    logic    k_clear;
    logic    k_advance;
    logic    out_load;
  } psms_cmd_t;

  typedef struct packed {
    logic              clr_done;
    logic              req_ok;
    logic              diag;
    logic [FUNC_W-1:0] func;
    logic              k_skip;
    logic              k_last;
    logic              out_free;
  } psms_stat_t;

  // Word of entry (x,y), x != y: hi*(hi-1)/2 + lo
  function automatic logic [SLOT_W-1:0] slot_of(logic [DIM_W-1:0] x, logic [DIM_W-1:0] y);
    logic [DIM_W-1:0]   lo;
    logic [DIM_W-1:0]   hi;
    logic [2*DIM_W-1:0] prod;
    lo   = (x < y) ? x : y;
    hi   = (x < y) ? y : x;
    prod = (2*DIM_W)'(hi) * (2*DIM_W)'(hi - 1'b1);
    return SLOT_W'(prod >> 1) + SLOT_W'(lo);
  endfunction

endpackage

>>> rtl/psms_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on psms_pkg for field widths.
interface psms_req_if;
  import psms_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [IDX_W-1:0]        index_a;
  logic [IDX_W-1:0]        index_b;
  logic signed [OPV_W-1:0] operand_value;

  modport source (output valid, func, index_a, index_b, operand_value, input ready);
  modport sink   (input valid, func, index_a, index_b, operand_value, output ready);
endinterface

interface psms_rsp_if;
  import psms_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OPV_W-1:0] read_value;
  logic [STATUS_W-1:0]     status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

>>> rtl/psms_ctrl.sv
// Controller for the packed symmetric matrix store: sequences the clearing
// pass, request decode, memory accesses and the swap walk. Uses psms_pkg.
module psms_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  psms_pkg::psms_stat_t stat,
  output psms_pkg::psms_cmd_t  cmd
);
  import psms_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_RD_WAIT,
    S_SW_CHK,
    S_SW_RD_Q,
    S_SW_WR_P,
    S_SW_WR_Q,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mem_op = MEM_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.req_ok || stat.diag) begin
          state_next = S_DONE;
        end else begin
          unique case (stat.func)
            FUNC_READ, FUNC_SUB: begin
              cmd.mem_op = MEM_RD_AB;
              state_next = S_RD_WAIT;
            end
            FUNC_WRITE: begin
              cmd.mem_op = MEM_WR_AB;
              state_next = S_DONE;
            end
            default: begin
              cmd.k_clear = 1'b1;
              state_next  = S_SW_CHK;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        if (stat.func == FUNC_SUB) begin
          cmd.mem_op = MEM_SUB_AB;
        end
        state_next = S_DONE;
      end
      S_SW_CHK: begin
        if (stat.k_skip) begin
          if (stat.k_last) begin
            state_next = S_DONE;
          end else begin
            cmd.k_advance = 1'b1;
          end
        end else begin
          cmd.mem_op = MEM_RD_P;
          state_next = S_SW_RD_Q;
        end
      end
      S_SW_RD_Q: begin
        cmd.mem_op = MEM_RD_Q;
        state_next = S_SW_WR_P;
      end
      S_SW_WR_P: begin
        cmd.mem_op = MEM_WR_P;
        state_next = S_SW_WR_Q;
      end
      S_SW_WR_Q: begin
        cmd.mem_op = MEM_WR_Q;
        if (stat.k_last) begin
          state_next = S_DONE;
        end else begin
          cmd.k_advance = 1'b1;
          state_next    = S_SW_CHK;
        end
      end
      S_DONE: begin
        // hold until the response register is free
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/psms_dpath.sv
// Datapath for the packed symmetric matrix store: request registers, range
// checks, slot address, triangle memory, swap counter and response register.
// Uses psms_pkg; driven by psms_ctrl commands.
module psms_dpath #(
  parameter int MAX_DIM    = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [psms_pkg::DIM_W-1:0]        cfg_wdata,
  input  logic [psms_pkg::FUNC_W-1:0]       func,
  input  logic [psms_pkg::IDX_W-1:0]        index_a,
  input  logic [psms_pkg::IDX_W-1:0]        index_b,
  input  logic signed [psms_pkg::OPV_W-1:0] operand_value,
  input  psms_pkg::psms_cmd_t               cmd,
  output psms_pkg::psms_stat_t              stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [psms_pkg::OPV_W-1:0] read_value,
  output logic [psms_pkg::STATUS_W-1:0]     status
);
  import psms_pkg::*;

  localparam int STORE_DEPTH = (MAX_DIM * (MAX_DIM - 1)) / 2;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int DIM_CAP     = (MAX_DIM > 127) ? 127 : MAX_DIM;

  logic [DATA_WIDTH-1:0] mem [STORE_DEPTH];
  logic [DATA_WIDTH-1:0] rdata;
  logic [DATA_WIDTH-1:0] tmp;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] opv_ext;
  logic signed [63:0]    rdata_ext;
  logic                  mem_we;
  logic                  mem_re;
  logic [ADDR_W-1:0]     addr;
  logic [ADDR_W-1:0]     clr_cnt;

  logic [DIM_W-1:0]        active_dimension;
  logic [DIM_W-1:0]        dim;
  logic [FUNC_W-1:0]       req_func;
  logic [DIM_W-1:0]        req_a;
  logic [DIM_W-1:0]        req_b;
  logic signed [OPV_W-1:0] req_opv;
  logic [DIM_W-1:0]        k;
  logic [STATUS_W-1:0]     req_status;
  logic                    diag;
  logic [DIM_W-1:0]        slot_x;
  logic [DIM_W-1:0]        slot_y;

  // effective dimension: register saturated to MAX_DIM, capped at 127
  assign dim = (active_dimension > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : active_dimension;
  assign diag = (req_a == req_b);

  always_comb begin
    if ((req_a >= dim) || (req_b >= dim)) begin
      req_status = ST_RANGE;
    end else if (diag && (req_func != FUNC_READ)) begin
      req_status = ST_EQUAL;
    end else begin
      req_status = ST_OK;
    end
  end

  assign stat.clr_done = (clr_cnt == ADDR_W'(STORE_DEPTH - 1));
  assign stat.req_ok   = (req_status == ST_OK);
  assign stat.diag     = diag;
  assign stat.func     = req_func;
  assign stat.k_skip   = (k == req_a) || (k == req_b);
  assign stat.k_last   = (k == dim - 1'b1);
  assign stat.out_free = !out_valid || out_ready;

  assign opv_ext   = DATA_WIDTH'(64'(req_opv));
  assign rdata_ext = 64'(signed'(rdata));

  // pair of indices that names the entry for this access
  always_comb begin
    slot_x = req_a;
    slot_y = req_b;
    case (cmd.mem_op)
      MEM_RD_P, MEM_WR_P: begin
        slot_x = k;
        slot_y = req_a;
      end
      MEM_RD_Q, MEM_WR_Q: begin
        slot_x = k;
        slot_y = req_b;
      end
      default: begin
        slot_x = req_a;
        slot_y = req_b;
      end
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    wdata  = '0;
    addr   = ADDR_W'(slot_of(slot_x, slot_y));
    if (cmd.clr_step) begin
      mem_we = 1'b1;
      addr   = clr_cnt;
    end else begin
      case (cmd.mem_op)
        MEM_RD_AB, MEM_RD_P, MEM_RD_Q: mem_re = 1'b1;
        MEM_WR_AB: begin
          mem_we = 1'b1;
          wdata  = opv_ext;
        end
        MEM_SUB_AB: begin
          mem_we = 1'b1;
          wdata  = rdata - opv_ext;
        end
        MEM_WR_P: begin
          mem_we = 1'b1;
          wdata  = rdata;
        end
        MEM_WR_Q: begin
          mem_we = 1'b1;
          wdata  = tmp;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt          <= '0;
      active_dimension <= RESET_DIM;
      out_valid        <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_we) begin
        active_dimension <= cfg_wdata;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_func <= func;
      req_a    <= {1'b0, index_a};
      req_b    <= {1'b0, index_b};
      req_opv  <= operand_value;
    end
    if (cmd.k_clear) begin
      k <= '0;
    end else if (cmd.k_advance) begin
      k <= k + 1'b1;
    end
    // keep the row-a word while its partner is read
    if (cmd.mem_op == MEM_RD_Q) begin
      tmp <= rdata;
    end
    if (cmd.out_load) begin
      status <= req_status;
      if ((req_status == ST_OK) && !diag && (req_func == FUNC_READ)) begin
        read_value <= rdata_ext[OPV_W-1:0];
      end else begin
        read_value <= '0;
      end
    end
  end

endmodule

>>> rtl/packed_symmetric_matrix_store.sv
// Packed symmetric matrix store: zero-diagonal matrix, strict lower triangle.
// A write or a refused request goes from the check straight to the response; a
// read or subtract first waits for its memory read; a swap makes four single-port
// memory accesses per other index. One request in flight: the next transfer can
// come in the cycle after the response loads; a full output holds it. Synchronous
// reset, then a clearing pass zeroes all MAX_DIM*(MAX_DIM-1)/2 memory words.
module packed_symmetric_matrix_store #(
  parameter int MAX_DIM    = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [psms_pkg::DIM_W-1:0] cfg_wdata,
  psms_req_if.sink                   req,
  psms_rsp_if.source                 rsp
);
  import psms_pkg::*;

  psms_cmd_t  cmd;
  psms_stat_t stat;

  psms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psms_dpath #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .func          (req.func),
    .index_a       (req.index_a),
    .index_b       (req.index_b),
    .operand_value (req.operand_value),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .read_value    (rsp.read_value),
    .status        (rsp.status)
  );

endmodule

>>> tb/packed_symmetric_matrix_store_tb.sv
// Self-checking bench for packed_symmetric_matrix_store: a directed table, then random
// phases over several dimension settings, every response checked against a local mirror.
// Depends on psms_pkg and the psms_req_if / psms_rsp_if interfaces.
module packed_symmetric_matrix_store_tb;
  import psms_pkg::*;

  localparam int N_DIM     = 64;
  localparam int N_WORDS   = N_DIM * (N_DIM - 1) / 2;
  localparam int LONG_HOLD = 300;

  typedef enum logic {ROW_REQ, ROW_DIM} row_kind_t;

  typedef struct packed {
    logic [OPV_W-1:0]    rv;
    logic [STATUS_W-1:0] st;
  } matrix_rsp_t;

  typedef struct {
    row_kind_t           kind;
    logic [FUNC_W-1:0]   fn;
    logic [IDX_W-1:0]    a;
    logic [IDX_W-1:0]    b;
    logic [OPV_W-1:0]    opv;
    bit                  pinned;
    logic [OPV_W-1:0]    rv;
    logic [STATUS_W-1:0] st;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [DIM_W-1:0]    cfg_wdata;
  bit                  pin_en;
  logic [OPV_W-1:0]    pin_rv;
  logic [STATUS_W-1:0] pin_st;
  bit                  quiet;
  bit                  hold_long;
  int                  fail_count;

  logic [OPV_W-1:0]    mirror_words [N_WORDS];
  logic [DIM_W-1:0]    mirror_dim;
  matrix_rsp_t         awaited_rsp [$];
  plan_row_t           plan [$];

  psms_req_if req_ch ();
  psms_rsp_if rsp_ch ();

  packed_symmetric_matrix_store u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #1 clk = ~clk;

  function automatic int word_of(int x, int y);
    int lo;
    int hi;
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    return hi * (hi - 1) / 2 + lo;
  endfunction

  // Apply one request to the mirror and return the response it owes.
  function automatic matrix_rsp_t matrix_apply(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] a,
                                               logic [IDX_W-1:0] b, logic [OPV_W-1:0] opv);
    matrix_rsp_t      r;
    int               lim;
    int               p;
    int               q;
    logic [OPV_W-1:0] t;
    r.rv = '0;
    r.st = ST_OK;
    lim  = (mirror_dim > N_DIM) ? N_DIM : int'(mirror_dim);
    if (a >= lim || b >= lim) begin
      r.st = ST_RANGE;
    end else if (a == b) begin
      if (fn != FUNC_READ) r.st = ST_EQUAL;
    end else begin
      p = word_of(a, b);
      case (fn)
        FUNC_READ:  r.rv = mirror_words[p];
        FUNC_WRITE: mirror_words[p] = opv;
        FUNC_SUB:   mirror_words[p] = mirror_words[p] - opv;
        default: begin
          // exchange row/column a with row/column b, below the dimension only
          for (int k = 0; k < lim; k++) begin
            if (k != a && k != b) begin
              p = word_of(k, a);
              q = word_of(k, b);
              t = mirror_words[p];
              mirror_words[p] = mirror_words[q];
              mirror_words[q] = t;
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic note_fault(string what, matrix_rsp_t want, matrix_rsp_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%s: expected value %h status %0d, got value %h status %0d",
               what, want.rv, want.st, got.rv, got.st);
  endtask

  always @(posedge clk) begin : track_and_check
    matrix_rsp_t want;
    matrix_rsp_t got;
    if (!rst) begin
      if (cfg_we) mirror_dim = cfg_wdata;
      if (req_ch.valid && req_ch.ready) begin
        want = matrix_apply(req_ch.func, req_ch.index_a, req_ch.index_b, req_ch.operand_value);
        if (pin_en) begin
          want.rv = pin_rv;
          want.st = pin_st;
        end
        awaited_rsp = {awaited_rsp, want};
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.rv = rsp_ch.read_value;
        got.st = rsp_ch.status;
        if (awaited_rsp.size() == 0) begin
          note_fault("unexpected response", '0, got);
        end else begin
          want = awaited_rsp.pop_front();
          if (got != want) note_fault("response mismatch", want, got);
        end
      end
    end
  end

  // Response side: random stall bursts, one long hold-off on request.
  initial begin : rsp_drain
    int n;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        hold_long = 1'b0;
        rsp_ch.ready <= 1'b0;
        for (n = 0; n < LONG_HOLD; n++) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Hold the request until transfer, then maybe drop valid for a burst.
  task automatic offer(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                       logic [OPV_W-1:0] opv, bit pinned, logic [OPV_W-1:0] prv,
                       logic [STATUS_W-1:0] pst);
    req_ch.valid         <= 1'b1;
    req_ch.func          <= fn;
    req_ch.index_a       <= a;
    req_ch.index_b       <= b;
    req_ch.operand_value <= opv;
    pin_en               <= pinned;
    pin_rv               <= prv;
    pin_st               <= pst;
    do @(posedge clk); while (!req_ch.ready);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic set_dim(logic [DIM_W-1:0] v);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] pick_index(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (lim == 0 || r < 8) return IDX_W'($urandom_range(0, N_DIM - 1));
    // favor a few low indices so reads land on entries already written
    if (r < 55) return IDX_W'($urandom_range(0, (lim < 6) ? lim - 1 : 5));
    return IDX_W'($urandom_range(0, lim - 1));
  endfunction

  task automatic run_phase(logic [DIM_W-1:0] dim_setting, int count, bit press);
    int                r;
    int                lim;
    logic [FUNC_W-1:0] fn;
    logic [IDX_W-1:0]  a;
    logic [IDX_W-1:0]  b;
    logic [OPV_W-1:0]  opv;
    set_dim(dim_setting);
    if (press) hold_long = 1'b1;
    lim = (dim_setting > N_DIM) ? N_DIM : int'(dim_setting);
    for (int i = 0; i < count; i++) begin
      r  = $urandom_range(0, 99);
      fn = (r < 35) ? FUNC_READ : (r < 60) ? FUNC_WRITE : (r < 88) ? FUNC_SUB : FUNC_SWAP;
      a  = pick_index(lim);
      b  = pick_index(lim);
      if ($urandom_range(0, 19) == 0) b = a;
      r   = $urandom_range(0, 9);
      opv = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7fff_ffff :
            (r == 2) ? 32'hffff_ffff : $urandom();
      offer(fn, a, b, opv, 1'b0, '0, ST_OK);
    end
  endtask

  function automatic void plan_req(logic [FUNC_W-1:0] fn, int a, int b, logic [OPV_W-1:0] opv);
    plan_row_t row;
    row  = '{ROW_REQ, fn, IDX_W'(a), IDX_W'(b), opv, 1'b0, '0, ST_OK};
    plan = {plan, row};
  endfunction

  function automatic void plan_pin(logic [FUNC_W-1:0] fn, int a, int b, logic [OPV_W-1:0] opv,
                                   logic [OPV_W-1:0] rv, logic [STATUS_W-1:0] st);
    plan_row_t row;
    row  = '{ROW_REQ, fn, IDX_W'(a), IDX_W'(b), opv, 1'b1, rv, st};
    plan = {plan, row};
  endfunction

  function automatic void plan_dim(logic [DIM_W-1:0] v);
    plan_row_t row;
    row  = '{ROW_DIM, FUNC_READ, '0, '0, OPV_W'(v), 1'b0, '0, ST_OK};
    plan = {plan, row};
  endfunction

  initial begin : stimulus
    plan_row_t row;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= RESET_DIM;
    req_ch.valid         <= 1'b0;
    req_ch.func          <= FUNC_READ;
    req_ch.index_a       <= '0;
    req_ch.index_b       <= '0;
    req_ch.operand_value <= '0;
    pin_en               <= 1'b0;
    pin_rv               <= '0;
    pin_st               <= ST_OK;
    quiet      = 1'b0;
    hold_long  = 1'b0;
    fail_count = 0;
    mirror_dim = RESET_DIM;
    foreach (mirror_words[i]) mirror_words[i] = '0;

    // fresh store, diagonal, extremes with wrap, both index orders
    plan_pin(FUNC_READ,   0,  1, '0,           '0,           ST_OK);
    plan_pin(FUNC_READ,   5,  5, 32'hdead_beef, '0,          ST_OK);
    plan_pin(FUNC_WRITE,  0,  1, 32'h7fff_ffff, '0,          ST_OK);
    plan_pin(FUNC_READ,   1,  0, '0,           32'h7fff_ffff, ST_OK);
    plan_pin(FUNC_WRITE, 62, 63, 32'h8000_0000, '0,          ST_OK);
    plan_pin(FUNC_READ,  63, 62, '0,           32'h8000_0000, ST_OK);
    plan_pin(FUNC_SUB,   62, 63, 32'h0000_0001, '0,          ST_OK);
    plan_pin(FUNC_READ,  62, 63, '0,           32'h7fff_ffff, ST_OK);
    plan_pin(FUNC_SUB,    0,  1, 32'hffff_ffff, '0,          ST_OK);
    plan_pin(FUNC_READ,   0,  1, '0,           32'h8000_0000, ST_OK);
    plan_pin(FUNC_WRITE,  3,  3, 32'h1234_5678, '0,          ST_EQUAL);
    plan_pin(FUNC_SWAP,   9,  9, '0,           '0,           ST_EQUAL);
    plan_req(FUNC_WRITE,  2,  9, 32'h1234_5678);
    plan_req(FUNC_WRITE,  5,  9, 32'ha5a5_a5a5);
    plan_pin(FUNC_SWAP,   2,  5, '0,           '0,           ST_OK);
    plan_req(FUNC_READ,   9,  5, '0);
    plan_req(FUNC_SWAP,   0, 63, '0);
    plan_req(FUNC_READ,   1, 63, '0);
    // shrunk dimension: range refusal wins over equal indices, store kept
    plan_dim(7'd4);
    plan_pin(FUNC_READ,   4,  0, '0,           '0,           ST_RANGE);
    plan_pin(FUNC_WRITE,  0, 63, 32'h5555_5555, '0,          ST_RANGE);
    plan_pin(FUNC_SWAP,   4,  4, '0,           '0,           ST_RANGE);
    plan_req(FUNC_SWAP,   0,  1, '0);
    plan_req(FUNC_READ,   1,  0, '0);
    plan_dim(7'd0);
    plan_pin(FUNC_READ,   0,  0, '0,           '0,           ST_RANGE);
    plan_dim(7'd127);
    plan_req(FUNC_READ,  62, 63, '0);
    plan_req(FUNC_READ,   0,  1, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_DIM) set_dim(row.opv[DIM_W-1:0]);
      else offer(row.fn, row.a, row.b, row.opv, row.pinned, row.rv, row.st);
    end

    run_phase(7'd64,  200, 1'b0);
    run_phase(7'd9,   120, 1'b0);
    run_phase(7'd1,    40, 1'b0);
    run_phase(7'd2,    60, 1'b0);
    run_phase(7'd127, 180, 1'b1);
    run_phase(7'd0,    30, 1'b0);
    run_phase(7'd33,  120, 1'b0);
    quiet = 1'b1;
    run_phase(7'd64,  150, 1'b0);

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0 && awaited_rsp.size() == 0) begin
      $display("packed_symmetric_matrix_store verification clean");
    end else begin
      $display("packed_symmetric_matrix_store verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("packed_symmetric_matrix_store verification failed");
    $finish;
  end

endmodule

>>> packed_symmetric_matrix_store.f
rtl/psms_pkg.sv
rtl/psms_if.sv
rtl/psms_ctrl.sv
rtl/psms_dpath.sv
rtl/packed_symmetric_matrix_store.sv
tb/packed_symmetric_matrix_store_tb.sv
